/* rtl/uw3d_pkg.sv */
package uw3d_pkg;

   // Field widths
   localparam int SYMBOL_W     = 8;
   localparam int ROW_LENGTH_W = 7;
   localparam int ROW_W        = 16;
   localparam int COL_OUT_W    = 6;
   localparam int COUNT_W      = 16;

   // Stream packing
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - (ROW_W + COL_OUT_W + COUNT_W);

   // Geometry
   localparam int DEF_MAX_ROW_LENGTH = 64;
   localparam int RESET_ROW_LENGTH   = 64;
   localparam int MIN_ROW_LENGTH     = 3;
   localparam int WIN_DIM            = 3;
   // first row / column index at which a full window exists
   localparam int MIN_TEST_INDEX     = 2;

   localparam logic [ROW_W-1:0]   ROW_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef logic [SYMBOL_W-1:0] symbol_type;

endpackage

/* rtl/uw3d_window.sv */
module uw3d_window (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  uw3d_pkg::symbol_type up2,
   input  uw3d_pkg::symbol_type up1,
   input  uw3d_pkg::symbol_type sym,
   output logic                 uniform
);
   import uw3d_pkg::*;

   // [row][col]; row 0 oldest, col 2 newest
   symbol_type win_ff [WIN_DIM][WIN_DIM];
   symbol_type win_in [WIN_DIM][WIN_DIM];

   always_comb begin
      for (int r = 0; r < WIN_DIM; r++) begin
         for (int c = 0; c < WIN_DIM - 1; c++) begin
            win_in[r][c] = win_ff[r][c+1];
         end
      end
      win_in[0][WIN_DIM-1] = up2;
      win_in[1][WIN_DIM-1] = up1;
      win_in[2][WIN_DIM-1] = sym;
   end

   // test is made on the window after this shift
   always_comb begin
      uniform = 1'b1;
      for (int r = 0; r < WIN_DIM; r++) begin
         for (int c = 0; c < WIN_DIM; c++) begin
            if (win_in[r][c] != win_in[0][0]) begin
               uniform = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < WIN_DIM; r++) begin
            for (int c = 0; c < WIN_DIM; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (shift_en) begin
         win_ff <= win_in;
      end
   end

endmodule

/* rtl/uniform_3x3_window_detector_unit.sv */
// Uniform 3x3 window detector. Symbols enter in raster order, one byte per
// req transaction (tdata = symbol, tuser[0] = grid start), in rows of the
// length written on the csr port (clamped to 3..MAX_ROW_LENGTH; write it only
// while the block is idle). Two line buffers, packed side by side in one
// single-port-read memory of MAX_ROW_LENGTH 16-bit entries, supply the two
// symbols above the current one; a 3x3 register window is shifted with each
// symbol. Whenever the window ending at a symbol (row >= 2, column >= 2) holds
// nine equal symbols, one rsp transaction carries the 1-based centre row,
// centre column and the running match count of the grid; row and count
// saturate at 65535. Throughput is one transaction per clock cycle while
// rsp_tready is high; a result held on rsp stalls stage 1, so req_tready drops
// after at most one more req transaction. A hit passes two register stages:
// the registered memory read alongside the stage-1 registers, then the output
// register, which drives rsp_tvalid and rsp_tdata.
// A write-to-read bypass covers a read that meets the line-buffer
// update of the preceding symbol. Buffer entries never written read as
// unknown; with a constant row length those reads never reach a result. No
// clearing pass is needed after reset.
module uniform_3x3_window_detector_unit #(
   parameter int MAX_ROW_LENGTH = uw3d_pkg::DEF_MAX_ROW_LENGTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration: row_length
   input  logic                                 csr_write_enable,
   input  logic [uw3d_pkg::ROW_LENGTH_W-1:0]    csr_write_data,
   // input stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [uw3d_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [7:0] symbol
   input  logic [uw3d_pkg::REQ_TUSER_W-1:0]     req_tuser,  // [0] grid_start
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] centre_row, [21:16] centre_column, [37:22] match_count, [39:38] 0
   output logic [uw3d_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import uw3d_pkg::*;

   localparam int COL_W   = $clog2(MAX_ROW_LENGTH);
   // wide enough for row_length, MAX_ROW_LENGTH and column + 1
   localparam int LEN_W   = (COL_W + 1 > ROW_LENGTH_W) ? COL_W + 1 : ROW_LENGTH_W;
   localparam int ENTRY_W = 2 * SYMBOL_W;
   localparam int RST_LEN = (RESET_ROW_LENGTH > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH
                                                                : RESET_ROW_LENGTH;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ROW_LENGTH);
   localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(MIN_ROW_LENGTH);
   localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(RST_LEN);

   // ---------------- configuration ----------------
   logic [LEN_W-1:0] len_ff, len_in, csr_ext;

   always_comb begin
      csr_ext = LEN_W'(csr_write_data);
      if (csr_ext < LEN_MIN) begin
         len_in = LEN_MIN;
      end else if (csr_ext > LEN_MAX) begin
         len_in = LEN_MAX;
      end else begin
         len_in = csr_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RST;
      end else if (csr_write_enable) begin
         len_ff <= len_in;
      end
   end

   // ---------------- stage 0: position counters, memory read ----------------
   logic             req_accept;
   logic             grid_start;
   symbol_type       req_symbol;
   logic [COL_W-1:0] col_ff, col_in, cur_col;
   logic [ROW_W-1:0] row_ff, row_in, cur_row;
   logic [LEN_W-1:0] col_inc;
   logic             row_wrap;

   assign req_symbol = req_tdata[SYMBOL_W-1:0];
   assign grid_start = req_tuser[0];
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      cur_col  = grid_start ? '0 : col_ff;
      cur_row  = grid_start ? '0 : row_ff;
      col_inc  = LEN_W'(cur_col) + LEN_W'(1);
      row_wrap = (col_inc >= len_ff);
      col_in   = row_wrap ? '0 : COL_W'(col_inc);
      row_in   = (row_wrap && (cur_row != ROW_MAX)) ? cur_row + ROW_W'(1) : cur_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line buffers: entry = {previous row symbol, older row symbol}
   logic [ENTRY_W-1:0] line_mem [MAX_ROW_LENGTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= line_mem[cur_col];
      end
   end

   // ---------------- stage 1: window update and test ----------------
   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   symbol_type       s1_sym_ff;
   logic             s1_start_ff;
   logic             s1_test_ff;
   logic             s1_adv;
   logic             rsp_valid_ff;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff   <= cur_col;
         s1_row_ff   <= cur_row;
         s1_sym_ff   <= req_symbol;
         s1_start_ff <= grid_start;
         s1_test_ff  <= (cur_row >= ROW_W'(MIN_TEST_INDEX)) &&
                        (cur_col >= COL_W'(MIN_TEST_INDEX));
      end
   end

   // bypass: the write of the preceding symbol lands on the edge of this read
   logic               fwd_valid_ff;
   logic [COL_W-1:0]   fwd_col_ff;
   logic [ENTRY_W-1:0] fwd_data_ff;
   logic               fwd_sel;
   logic [ENTRY_W-1:0] entry;
   logic [ENTRY_W-1:0] wr_entry;
   symbol_type         up2, up1;

   assign fwd_sel  = fwd_valid_ff && (fwd_col_ff == s1_col_ff);
   assign entry    = fwd_sel ? fwd_data_ff : rd_data_ff;
   assign up2      = entry[SYMBOL_W-1:0];
   assign up1      = entry[ENTRY_W-1:SYMBOL_W];
   assign wr_entry = {s1_sym_ff, up1};

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_col_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         fwd_col_ff  <= s1_col_ff;
         fwd_data_ff <= wr_entry;
      end
   end

   logic uniform;
   logic hit;

   uw3d_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_adv),
      .up2      (up2),
      .up1      (up1),
      .sym      (s1_sym_ff),
      .uniform  (uniform)
   );

   assign hit = s1_test_ff && uniform;

   // match counter lives with the test result
   logic [COUNT_W-1:0] match_ff, match_in, match_base;

   always_comb begin
      match_base = s1_start_ff ? '0 : match_ff;
      match_in   = (hit && (match_base != COUNT_MAX)) ? match_base + COUNT_W'(1)
                                                      : match_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
      end else if (s1_adv) begin
         match_ff <= match_in;
      end
   end

   // ---------------- output register ----------------
   logic [ROW_W-1:0]     rsp_row_ff;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= hit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && hit) begin
         rsp_row_ff   <= s1_row_ff;
         rsp_col_ff   <= COL_OUT_W'(s1_col_ff);
         rsp_count_ff <= match_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_count_ff, rsp_col_ff, rsp_row_ff};

   // ---------------- assertions ----------------
   a_hit_to_rsp : assert property (@(posedge clock) disable iff (reset)
      (s1_adv && hit) |=> rsp_valid_ff)
      else $error("detected window did not reach the output register");

   a_bypass : assert property (@(posedge clock) disable iff (reset)
      (req_accept && s1_adv && (cur_col == s1_col_ff)) |=> fwd_sel)
      else $error("line buffer bypass missed a colliding read");

   a_rsp_sane : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_count_ff != '0) &&
                        (rsp_row_ff >= ROW_W'(MIN_TEST_INDEX))))
      else $error("result with zero count or row above the first full window");

endmodule
